// ===== src/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes, types and helpers of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;

   localparam int CMD_W  = 2;
   localparam int POS_W  = 6;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 6;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W + 1 : CNT_W + 1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic [ADDR_W-1:0]     rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [LEN_W-1:0]        length;
      logic signed [VAL_W-1:0] read_value;
   } rsp_beat_type;

   // Sign-extend a stored word and cut it to the result field.
   function automatic logic signed [VAL_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
      logic [DATA_WIDTH+VAL_W-1:0] ext;
      ext = {{VAL_W{d[DATA_WIDTH-1]}}, d};
      return ext[VAL_W-1:0];
   endfunction

   // Sign-extend an input value and keep the stored width.
   function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
      logic [DATA_WIDTH+VAL_W-1:0] ext;
      ext = {{DATA_WIDTH{v[VAL_W-1]}}, v};
      return ext[DATA_WIDTH-1:0];
   endfunction

endpackage

// ===== src/ple_if.sv =====
// ----------------------------------------------------------------------------
// ple_req_if / ple_rsp_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface ple_req_if;
   import ple_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic [LEN_W-1:0]        length;
   logic signed [VAL_W-1:0] read_value;

   modport source (output valid, output status, output length, output read_value,
                   input ready);
   modport sink   (input valid, input status, input length, input read_value,
                   output ready);
endinterface

// ===== src/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed words with insert, erase and read by position.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one command beat: cmd (insert, erase, read), a zero-based
//    position and, for insert, the value. Insert at position equal to the
//    length appends.
//  - rsp returns exactly one beat per command: status (ok, full, out of
//    range, empty), the length after the command, and the element read or
//    erased (zero otherwise). Failed commands leave the list untouched.
//  - The list lives in one element RAM with a registered read.
//    Insert and erase move every element behind the position by one slot,
//    one element per cycle through that single RAM port pair.
//  - An error goes straight to the result stage; a read, an append or an
//    erase of the last element passes through one RAM read or write state
//    first, and an insert or erase that shifts also runs the shift loop
//    through the RAM. req is taken again the cycle after the result beat
//    leaves the sequencer, so a new command is not accepted until the last
//    one is through the sequencer.
//  - Reset empties the list; no RAM sweep is needed because
//    only entries below the length are ever read.
//  - While rsp is stalled the finished beat holds in the output register;
//    the next command is accepted meanwhile and waits for the slot to free.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
   input  logic       clock,
   input  logic       reset,
   ple_req_if.sink    req,
   ple_rsp_if.source  rsp
);
   import ple_pkg::*;

   ram_req_type           ram;
   logic [DATA_WIDTH-1:0] rd_data;
   rsp_beat_type          beat;
   logic                  emit;
   logic                  slot_free;

   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_beat_ff;

   // the output slot frees when empty or when its beat is taken this cycle
   assign slot_free = !rsp_valid_ff || rsp.ready;

   ple_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .slot_free (slot_free),
      .emit      (emit),
      .beat      (beat),
      .ram       (ram),
      .rd_data   (rd_data)
   );

   ple_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load a new beat on emit, drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_beat_ff <= beat;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_beat_ff.status;
   assign rsp.length     = rsp_beat_ff.length;
   assign rsp.read_value = rsp_beat_ff.read_value;
endmodule

// ===== src/ple_ram.sv =====
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/ple_seq.sv =====
// ----------------------------------------------------------------------------
// ple_seq
// Command sequencer: checks each command, shifts list entries through the
// element RAM one per cycle, and hands a finished result to the output stage.
// ----------------------------------------------------------------------------
module ple_seq (
   input  logic                          clock,
   input  logic                          reset,
   ple_req_if.sink                       req,
   input  logic                          slot_free,
   output logic                          emit,
   output ple_pkg::rsp_beat_type         beat,
   output ple_pkg::ram_req_type          ram,
   input  logic [ple_pkg::DATA_WIDTH-1:0] rd_data
);
   import ple_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CAPTURE, S_SHIFT, S_PUT, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic signed [VAL_W-1:0] result_ff, result_in;
   logic [ADDR_W-1:0]     cur_ff, cur_in;
   logic [ADDR_W-1:0]     last_ff, last_in;
   logic [ADDR_W-1:0]     dst_ff, dst_in;
   logic                  pend_ff, pend_in;
   logic                  more_ff, more_in;
   logic                  up_ff, up_in;

   logic [CMP_W-1:0]      req_pos_c, count_c, pos_ff_c;
   logic [CNT_W-1:0]      new_count;

   assign req_pos_c = CMP_W'(req.position);
   assign count_c   = CMP_W'(count_ff);
   assign pos_ff_c  = CMP_W'(pos_ff);

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      new_count = count_ff;
      if (status_ff == ST_OK) begin
         if (cmd_ff == CMD_INSERT) begin
            new_count = count_ff + CNT_W'(1);
         end else if (cmd_ff == CMD_ERASE) begin
            new_count = count_ff - CNT_W'(1);
         end
      end
   end

   assign emit            = (state_ff == S_DONE) && slot_free;
   assign beat.status     = status_ff;
   assign beat.length     = LEN_W'(new_count);
   assign beat.read_value = result_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      result_in = result_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      dst_in    = dst_ff;
      pend_in   = pend_ff;
      more_in   = more_ff;
      up_in     = up_ff;

      ram.wr_en   = 1'b0;
      ram.wr_addr = dst_ff;
      ram.wr_data = rd_data;
      ram.rd_addr = cur_ff;

      case (state_ff)
         S_IDLE: begin
            ram.rd_addr = req.position[ADDR_W-1:0];
            if (req.valid) begin
               cmd_in    = req.cmd;
               pos_in    = req.position[ADDR_W-1:0];
               val_in    = to_store(req.value);
               result_in = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               if (req.cmd == CMD_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else if (req_pos_c > count_c) begin
                     status_in = ST_RANGE;
                  end else if (req_pos_c == count_c) begin
                     state_in = S_PUT;
                  end else begin
                     // open a hole at the position: move the tail up by one
                     cur_in   = ADDR_W'(count_ff - CNT_W'(1));
                     last_in  = req.position[ADDR_W-1:0];
                     up_in    = 1'b1;
                     more_in  = 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_SHIFT;
                  end
               end else if (req.cmd inside {CMD_ERASE, CMD_READ}) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (req_pos_c >= count_c) begin
                     status_in = ST_RANGE;
                  end else begin
                     state_in = S_CAPTURE;
                  end
               end else begin
                  status_in = ST_RANGE;
               end
            end
         end

         S_CAPTURE: begin
            result_in = to_field(rd_data);
            state_in  = S_DONE;
            if (cmd_ff == CMD_ERASE && (pos_ff_c + CMP_W'(1)) < count_c) begin
               // close the gap: move the tail down by one
               cur_in   = pos_ff + ADDR_W'(1);
               last_in  = ADDR_W'(count_ff - CNT_W'(1));
               up_in    = 1'b0;
               more_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            ram.rd_addr = cur_ff;
            ram.wr_en   = pend_ff;
            ram.wr_addr = dst_ff;
            ram.wr_data = rd_data;
            if (more_ff) begin
               pend_in = 1'b1;
               dst_in  = up_ff ? cur_ff + ADDR_W'(1) : cur_ff - ADDR_W'(1);
               if (cur_ff == last_ff) begin
                  more_in = 1'b0;
               end else begin
                  cur_in = up_ff ? cur_ff - ADDR_W'(1) : cur_ff + ADDR_W'(1);
               end
            end else begin
               pend_in  = 1'b0;
               state_in = (cmd_ff == CMD_INSERT) ? S_PUT : S_DONE;
            end
         end

         S_PUT: begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = pos_ff;
            ram.wr_data = val_ff;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (slot_free) begin
               count_in = new_count;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         more_ff  <= more_in;
      end
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      result_ff <= result_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      dst_ff    <= dst_in;
      up_ff     <= up_in;
   end
endmodule

// ===== verif/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine: drives insert, erase,
// read and spare commands over the request channel, keeps a shadow copy of
// the list to predict every result beat, and checks each beat field by field.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
   import ple_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, must report out of range
   localparam int ITEM_TARGET  = 1450;
   localparam int HOLD_AT      = 300;   // item count that triggers the long result stall
   localparam int HOLD_CYCLES  = 300;
   localparam int PAUSE_AT     = 900;   // item count at which the sender drains the block
   localparam int CALM_FROM    = 1000;  // no idling on either side in this window
   localparam int CALM_TO      = 1200;
   localparam int IDLE_PCT     = 16;
   localparam int SETTLE_CYCLES = 80;

   // -------------------------------------------------------------------------
   // Shadow list: predicts one result beat per accepted command and checks
   // the beats that leave the block in order.
   // -------------------------------------------------------------------------
   class list_tracker;
      logic signed [DATA_WIDTH-1:0] slot [CAPACITY];
      int unsigned  count;
      int unsigned  peak;
      rsp_beat_type pending_results [$];
      int unsigned  mismatches;
      int unsigned  checked;
      int unsigned  status_hits [4];
      int unsigned  cmd_hits [4];

      function void note_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] value);
         rsp_beat_type beat;
         int unsigned  p;
         p = pos;
         beat.status = ST_OK;
         beat.read_value = '0;
         cmd_hits[cmd]++;
         if (cmd == CMD_INSERT) begin
            if (count >= CAPACITY) begin
               beat.status = ST_FULL;
            end else if (p > count) begin
               beat.status = ST_RANGE;
            end else begin
               for (int i = count; i > p; i--) slot[i] = slot[i-1];
               slot[p] = value;   // keep the low DATA_WIDTH bits
               count++;
            end
         end else if (cmd == CMD_ERASE || cmd == CMD_READ) begin
            if (count == 0) begin
               beat.status = ST_EMPTY;
            end else if (p >= count) begin
               beat.status = ST_RANGE;
            end else begin
               beat.read_value = slot[p];   // sign-extend back to the field
               if (cmd == CMD_ERASE) begin
                  for (int i = p; i + 1 < count; i++) slot[i] = slot[i+1];
                  count--;
               end
            end
         end else begin
            beat.status = ST_RANGE;
         end
         beat.length = LEN_W'(count);
         if (count > peak) peak = count;
         status_hits[beat.status]++;
         pending_results.push_back(beat);
      endfunction

      function void check_result(input logic [STAT_W-1:0] status,
                                 input logic [LEN_W-1:0] length,
                                 input logic signed [VAL_W-1:0] read_value);
         rsp_beat_type want;
         if (pending_results.size() == 0) begin
            $error("result beat with no command pending: status %0d length %0d value %0d",
                   status, length, read_value);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (length !== want.length) begin
            $error("length mismatch: expected %0d, actual %0d", want.length, length);
            mismatches++;
         end
         if (read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   want.read_value, read_value);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   positional_list_engine_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   list_tracker tracker = new();

   int unsigned items_sent;
   bit          calm;          // suppress random idling on both sides
   bit          hold_off_req;  // ask the result side for one long stall
   bit          hold_done;

   // -------------------------------------------------------------------------
   // Clock and the run limit.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Slowest legal run of about 1450 beats plus stalls stays far below this
   // limit.
   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: random back-pressure, one long hold-off on request.
   // -------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            // Hold ready low long enough for the block to fill its output
            // slot and stop taking commands.
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Check every result beat that leaves the block.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            tracker.check_result(rsp_ch.status, rsp_ch.length, rsp_ch.read_value);
      end
   end

   // -------------------------------------------------------------------------
   // Command side.
   // -------------------------------------------------------------------------

   // Offer one command beat and return once the block has taken it. Valid is
   // lowered only on idle cycles, so a back-to-back beat keeps it high.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] value);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.position <= pos;
      req_ch.value    <= value;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_command(cmd, pos, value);
      items_sent++;
   endtask

   // Lean on the sign boundaries now and then.
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Pick a legal position in 0..hi, biased toward both ends.
   function automatic logic [POS_W-1:0] pick_pos(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return '0;
      if (r < 40) return POS_W'(hi);
      return POS_W'($urandom_range(0, hi));
   endfunction

   // Insert, erase or read with a mostly legal position.
   task automatic mixed_cmd();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      n = tracker.count;
      if (r < 40) begin
         if ($urandom_range(0, 9) == 0)
            send_cmd(CMD_INSERT, POS_W'($urandom_range(n + 1, 63)), pick_value());
         else
            send_cmd(CMD_INSERT, pick_pos(n), pick_value());
      end else begin
         if (n == 0 || $urandom_range(0, 9) == 0)
            send_cmd(r < 70 ? CMD_ERASE : CMD_READ, POS_W'($urandom_range(n, 63)),
                     pick_value());
         else
            send_cmd(r < 70 ? CMD_ERASE : CMD_READ, pick_pos(n - 1), pick_value());
      end
   endtask

   // Fill the list to capacity, then push past it.
   task automatic fill_burst();
      int unsigned extra;
      extra = $urandom_range(1, 3);
      while (tracker.count < CAPACITY) begin
         if (tracker.count > 0 && $urandom_range(0, 4) == 0)
            send_cmd(CMD_READ, pick_pos(tracker.count - 1), pick_value());
         else
            send_cmd(CMD_INSERT, pick_pos(tracker.count), pick_value());
      end
      repeat (extra) send_cmd(CMD_INSERT, POS_W'($urandom_range(0, 63)), pick_value());
   endtask

   // Drain the list to empty, then poke the empty list.
   task automatic drain_burst();
      int unsigned extra;
      extra = $urandom_range(1, 2);
      while (tracker.count > 0) begin
         send_cmd($urandom_range(0, 4) == 0 ? CMD_READ : CMD_ERASE,
                  pick_pos(tracker.count - 1), pick_value());
      end
      repeat (extra)
         send_cmd($urandom_range(0, 1) ? CMD_ERASE : CMD_READ,
                  POS_W'($urandom_range(0, 63)), pick_value());
   endtask

   initial begin
      int unsigned r;
      int unsigned len;
      bit          paused;
      bit          first;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;
      paused          = 1'b0;
      first           = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, out-of-range on each command, both ends of
      // the value range, front, middle and back of the list.
      send_cmd(CMD_READ,   0,  pick_value());
      send_cmd(CMD_ERASE,  0,  pick_value());
      send_cmd(CMD_INSERT, 1,  32'sd5);          // past the end of an empty list
      send_cmd(CMD_SPARE,  0,  32'sd0);
      send_cmd(CMD_INSERT, 0,  32'sh7fff_ffff);
      send_cmd(CMD_INSERT, 0,  32'sh8000_0000);  // new head
      send_cmd(CMD_INSERT, 2,  32'shffff_ffff);  // append
      send_cmd(CMD_INSERT, 1,  32'sd0);          // middle
      send_cmd(CMD_READ,   0,  '0);
      send_cmd(CMD_READ,   1,  '0);
      send_cmd(CMD_READ,   2,  '0);
      send_cmd(CMD_READ,   3,  '0);
      send_cmd(CMD_READ,   4,  '0);              // one past the last element
      send_cmd(CMD_READ,   63, '1);
      send_cmd(CMD_ERASE,  63, '0);
      send_cmd(CMD_INSERT, 63, '1);
      send_cmd(CMD_ERASE,  1,  '0);              // middle
      send_cmd(CMD_ERASE,  0,  '0);              // head
      send_cmd(CMD_ERASE,  1,  '0);              // tail
      send_cmd(CMD_READ,   0,  '0);
      send_cmd(CMD_ERASE,  0,  '0);              // last element out
      send_cmd(CMD_READ,   0,  '0);
      send_cmd(CMD_SPARE,  63, '1);

      // Random bursts; open with a fill so the full case shows up early.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= HOLD_AT) hold_off_req = 1'b1;
         calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
         if (!paused && items_sent >= PAUSE_AT) begin
            // Drop valid and let every outstanding result come back.
            paused = 1'b1;
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (tracker.pending_results.size() != 0);
         end
         r = first ? 0 : $urandom_range(0, 99);
         first = 1'b0;
         if (r < 25) begin
            fill_burst();
         end else if (r < 50) begin
            drain_burst();
         end else if (r < 85) begin
            len = $urandom_range(20, 60);
            repeat (len) mixed_cmd();
         end else begin
            // Noise: any code, any position.
            len = $urandom_range(5, 15);
            repeat (len)
               send_cmd(CMD_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)),
                        pick_value());
         end
      end
      calm = 1'b0;

      // Drop valid, wait out the last results and any stray beat.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d commands (insert %0d, erase %0d, read %0d, spare %0d), checked %0d.",
               items_sent, tracker.cmd_hits[0], tracker.cmd_hits[1], tracker.cmd_hits[2],
               tracker.cmd_hits[3], tracker.checked);
      $display("Status ok %0d, full %0d, range %0d, empty %0d; peak length %0d of %0d.",
               tracker.status_hits[0], tracker.status_hits[1], tracker.status_hits[2],
               tracker.status_hits[3], tracker.peak, CAPACITY);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ple_pkg.sv
src/ple_if.sv
src/ple_ram.sv
src/ple_seq.sv
src/positional_list_engine_unit.sv
verif/tb_positional_list_engine_unit.sv
